/* rtl/pifl_pkg.sv */
// Package for the fan-out indexed key lookup block.
// Holds the command codes, field widths and the key and entry types.
// No dependencies.
package pifl_pkg;

  localparam int CMD_W       = 2;
  localparam int SLOT_W      = 12;
  localparam int POS_W       = 12;
  localparam int OFFSET_W    = 32;
  localparam int VALUE_W     = 32;
  localparam int BUCKET_W    = 8;
  localparam int FANOUT_DEPTH = 256;

  localparam logic [CMD_W-1:0] CMD_FANOUT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENTRY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // Byte 0 of the key sits in the top bits, so the packed vector compares
  // as a big-endian unsigned number.
  typedef struct packed {
    logic [31:0] top;
    logic [63:0] mid;
    logic [63:0] low;
  } key_t;

  typedef struct packed {
    key_t                key;
    logic [OFFSET_W-1:0] offset;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/pifl_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Used for the fan-out table and for the key and offset table. No dependencies.
module pifl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/pifl_ctrl.sv */
// Command sequencer: performs table writes and runs the fan-out read and the
// binary search, one probe of the entry memory per cycle. Depends on pifl_pkg.
module pifl_ctrl import pifl_pkg::*; #(
  parameter int MAX_ENTRIES = 4096,
  parameter int AW          = $clog2(MAX_ENTRIES),
  parameter int FW          = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [31:0]         key_top,
  input  logic [63:0]         key_mid,
  input  logic [63:0]         key_low,
  input  logic [VALUE_W-1:0]  write_value,
  output logic                done,
  output logic                found,
  output logic [POS_W-1:0]    position,
  output logic [OFFSET_W-1:0] entry_offset,
  // fan-out memory
  output logic                fan_we,
  output logic [BUCKET_W-1:0] fan_waddr,
  output logic [FW-1:0]       fan_wdata,
  output logic [BUCKET_W-1:0] fan_raddr,
  input  logic [FW-1:0]       fan_rdata,
  // entry memory
  output logic                ent_we,
  output logic [AW-1:0]       ent_waddr,
  output entry_t              ent_wdata,
  output logic [AW-1:0]       ent_raddr,
  input  entry_t              ent_rdata
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FAN_HI = 4'b0010,
    ST_FAN_LO = 4'b0100,
    ST_SEARCH = 4'b1000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [BUCKET_W-1:0] bucket;
  key_t                key;
  logic [FW-1:0]       lo;
  logic [FW-1:0]       hi;
  logic [FW-1:0]       mid;

  logic                accept;
  key_t                in_key;
  logic [FW-1:0]       rng_lo;
  logic [FW-1:0]       rng_hi;
  logic [FW-1:0]       rng_mid;
  logic                rng_empty;
  logic                hit;
  logic                finish;
  logic                fin_found;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);
  assign in_key = '{top: key_top, mid: key_mid, low: key_low};

  // Write ports take the request on the edge that accepts it.
  assign fan_we    = accept && (cmd == CMD_FANOUT) && (slot[SLOT_W-1:BUCKET_W] == '0);
  assign fan_waddr = slot[BUCKET_W-1:0];
  assign fan_wdata = (write_value > VALUE_W'(MAX_ENTRIES)) ? FW'(MAX_ENTRIES)
                                                           : FW'(write_value);
  assign ent_we    = accept && (cmd == CMD_ENTRY) && (32'(slot) < 32'(MAX_ENTRIES));
  assign ent_waddr = AW'(slot);
  assign ent_wdata = '{key: in_key, offset: write_value};

  // The upper bound is read first, then the lower bound from the bucket below.
  assign fan_raddr = (state == ST_IDLE) ? key_top[31:24] : bucket - BUCKET_W'(1);

  assign hit = (ent_rdata.key == key);

  // Range for the next probe. In the search state both halves are formed in
  // parallel with the key compare and the compare only selects.
  always_comb begin
    unique case (state)
      ST_FAN_HI: begin
        rng_lo = '0;
        rng_hi = fan_rdata;
      end
      ST_FAN_LO: begin
        rng_lo = fan_rdata;
        rng_hi = hi;
      end
      ST_SEARCH: begin
        if (ent_rdata.key > key) begin
          rng_lo = lo;
          rng_hi = mid;
        end else begin
          rng_lo = mid + FW'(1);
          rng_hi = hi;
        end
      end
      default: begin
        rng_lo = lo;
        rng_hi = hi;
      end
    endcase
  end

  assign rng_empty = (rng_lo >= rng_hi);
  assign rng_mid   = rng_lo + ((rng_hi - rng_lo) >> 1);
  assign ent_raddr = rng_mid[AW-1:0];

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    fin_found  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_LOOKUP) begin
            state_next = ST_FAN_HI;
          end else begin
            finish = 1'b1;
          end
        end
      end
      ST_FAN_HI: begin
        if (bucket != '0) begin
          state_next = ST_FAN_LO;
        end else if (rng_empty) begin
          state_next = ST_IDLE;
          finish     = 1'b1;
        end else begin
          state_next = ST_SEARCH;
        end
      end
      ST_FAN_LO: begin
        if (rng_empty) begin
          state_next = ST_IDLE;
          finish     = 1'b1;
        end else begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          state_next = ST_IDLE;
          finish     = 1'b1;
          fin_found  = 1'b1;
        end else if (rng_empty) begin
          state_next = ST_IDLE;
          finish     = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key    <= in_key;
      bucket <= key_top[31:24];
    end
    if (state != ST_IDLE) begin
      lo  <= rng_lo;
      hi  <= rng_hi;
      mid <= rng_mid;
    end
    if (finish) begin
      found        <= fin_found;
      position     <= fin_found ? POS_W'(mid) : '0;
      entry_offset <= fin_found ? ent_rdata.offset : '0;
    end
  end

endmodule

/* rtl/pack_index_fanout_lookup_core.sv */
// Top level of the fan-out indexed key lookup block.
// Instantiates pifl_ctrl and two pifl_ram memories; depends on pifl_pkg.
//
//   channel  | handshake            | fields
//   ---------+----------------------+------------------------------------------
//   request  | start in, busy out   | cmd, slot, key_top, key_mid, key_low,
//            |                      | write_value
//   result   | done out (1 cycle)   | found, position, entry_offset
//
// A request is taken when start is high and busy is low. Write and unused
// commands leave busy low; done rises in the cycle after the request is taken.
// A lookup reads the upper fan-out bound, then the lower one unless the key is
// in bucket 0, then makes one probe of the entry memory per cycle, at most
// clog2(MAX_ENTRIES)+1 probes; the entry memory's single read port sets that pace.
// rst clears the sequencer only; the tables hold no defined contents until
// written. The receiver cannot stall: each result shows for exactly one cycle.
module pack_index_fanout_lookup_core import pifl_pkg::*; #(
  parameter int MAX_ENTRIES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [31:0]         key_top,
  input  logic [63:0]         key_mid,
  input  logic [63:0]         key_low,
  input  logic [VALUE_W-1:0]  write_value,
  output logic                done,
  output logic                found,
  output logic [POS_W-1:0]    position,
  output logic [OFFSET_W-1:0] entry_offset
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int FW = $clog2(MAX_ENTRIES + 1);

  logic                fan_we;
  logic [BUCKET_W-1:0] fan_waddr;
  logic [FW-1:0]       fan_wdata;
  logic [BUCKET_W-1:0] fan_raddr;
  logic [FW-1:0]       fan_rdata;
  logic                ent_we;
  logic [AW-1:0]       ent_waddr;
  entry_t              ent_wdata;
  logic [AW-1:0]       ent_raddr;
  entry_t              ent_rdata;

  pifl_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW),
    .FW          (FW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .slot         (slot),
    .key_top      (key_top),
    .key_mid      (key_mid),
    .key_low      (key_low),
    .write_value  (write_value),
    .done         (done),
    .found        (found),
    .position     (position),
    .entry_offset (entry_offset),
    .fan_we       (fan_we),
    .fan_waddr    (fan_waddr),
    .fan_wdata    (fan_wdata),
    .fan_raddr    (fan_raddr),
    .fan_rdata    (fan_rdata),
    .ent_we       (ent_we),
    .ent_waddr    (ent_waddr),
    .ent_wdata    (ent_wdata),
    .ent_raddr    (ent_raddr),
    .ent_rdata    (ent_rdata)
  );

  pifl_ram #(
    .WIDTH (FW),
    .DEPTH (FANOUT_DEPTH),
    .AW    (BUCKET_W)
  ) u_fanout_ram (
    .clk   (clk),
    .we    (fan_we),
    .waddr (fan_waddr),
    .wdata (fan_wdata),
    .raddr (fan_raddr),
    .rdata (fan_rdata)
  );

  pifl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

endmodule

/* test/pack_index_fanout_lookup_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for pack_index_fanout_lookup_core: loads fan-out words and
// sorted key entries, then checks lookups against a predictor kept in this file.
// Depends on pifl_pkg and the RTL of the block; reads and writes no files.
module pack_index_fanout_lookup_core_tb;
  import pifl_pkg::*;

  localparam int MAX_ENTRIES = 4096;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 230;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DIRECTED_COUNT = 19;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_W-1:0]  slot;
    key_t               key;
    logic [VALUE_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic                hit;
    logic [POS_W-1:0]    pos;
    logic [OFFSET_W-1:0] ofs;
  } outcome_t;

  typedef struct packed {
    request_t req;
    bit       typed;
    outcome_t want;
  } row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    cmd = '0;
  logic [SLOT_W-1:0]   slot = '0;
  logic [31:0]         key_top = '0;
  logic [63:0]         key_mid = '0;
  logic [63:0]         key_low = '0;
  logic [VALUE_W-1:0]  write_value = '0;
  logic                done;
  logic                found;
  logic [POS_W-1:0]    position;
  logic [OFFSET_W-1:0] entry_offset;

  // Mirror of the block's tables, plus which words have been written so far.
  logic [12:0]         fanout_words [FANOUT_DEPTH];
  key_t                stored_keys [MAX_ENTRIES];
  logic [OFFSET_W-1:0] stored_offsets [MAX_ENTRIES];
  bit                  fanout_seen [FANOUT_DEPTH];
  bit                  entry_seen [MAX_ENTRIES];

  // The well-formed index that the random part builds and keeps restoring.
  int unsigned bucket_size [FANOUT_DEPTH];
  int unsigned index_fanout [FANOUT_DEPTH];
  int unsigned index_total;

  outcome_t    expected_results [$];
  row_t        directed_rows [DIRECTED_COUNT];
  int unsigned gap_pct;
  int unsigned useful_sent;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  pack_index_fanout_lookup_core #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .slot(slot),
    .key_top(key_top),
    .key_mid(key_mid),
    .key_low(key_low),
    .write_value(write_value),
    .done(done),
    .found(found),
    .position(position),
    .entry_offset(entry_offset)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic outcome_t predict_outcome(request_t r);
    outcome_t    o;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [7:0]  bucket;
    o = '0;
    case (r.cmd)
      CMD_FANOUT: begin
        if (r.slot < FANOUT_DEPTH) begin
          fanout_words[r.slot[7:0]] = (r.value > MAX_ENTRIES) ? 13'(MAX_ENTRIES)
                                                              : r.value[12:0];
        end
      end
      CMD_ENTRY: begin
        stored_keys[r.slot] = r.key;
        stored_offsets[r.slot] = r.value;
      end
      CMD_LOOKUP: begin
        bucket = r.key.top[31:24];
        hi = 32'(fanout_words[bucket]);
        lo = (bucket == 0) ? 0 : 32'(fanout_words[bucket - 1]);
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (stored_keys[mid] == r.key) begin
            o.hit = 1'b1;
            o.pos = mid[POS_W-1:0];
            o.ofs = stored_offsets[mid];
            break;
          end else if (stored_keys[mid] > r.key) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // A lookup may only touch fan-out words and entries that have been written.
  function automatic bit lookup_safe(logic [7:0] b);
    int unsigned lo;
    int unsigned hi;
    if (!fanout_seen[b] || (b != 0 && !fanout_seen[b - 1])) return 1'b0;
    hi = 32'(fanout_words[b]);
    lo = (b == 0) ? 0 : 32'(fanout_words[b - 1]);
    for (int unsigned p = lo; p < hi; p++) begin
      if (!entry_seen[p]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic request_t make_req(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] s,
                                        key_t k, logic [VALUE_W-1:0] v);
    request_t r;
    r.cmd = c;
    r.slot = s;
    r.key = k;
    r.value = v;
    return r;
  endfunction

  function automatic row_t dir_row(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] s,
                                   logic [31:0] t, logic [63:0] m, logic [63:0] l,
                                   logic [VALUE_W-1:0] v, bit typed, logic h,
                                   logic [POS_W-1:0] p, logic [OFFSET_W-1:0] o);
    row_t d;
    d.req = make_req(c, s, {t, m, l}, v);
    d.typed = typed;
    d.want = {h, p, o};
    return d;
  endfunction

  function automatic key_t rand_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic int unsigned bucket_base(int unsigned b);
    return (b == 0) ? 0 : index_fanout[b - 1];
  endfunction

  // Sender idles at random, then holds the request until the block takes it.
  task automatic send_request(request_t r, bit typed = 1'b0, outcome_t want = '0);
    outcome_t predicted;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    start <= 1'b1;
    cmd <= r.cmd;
    slot <= r.slot;
    key_top <= r.key.top;
    key_mid <= r.key.mid;
    key_low <= r.key.low;
    write_value <= r.value;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_outcome(r);
    expected_results.push_back(typed ? want : predicted);
    if (r.cmd == CMD_FANOUT && r.slot < FANOUT_DEPTH) fanout_seen[r.slot[7:0]] = 1'b1;
    if (r.cmd == CMD_ENTRY) entry_seen[r.slot] = 1'b1;
    if (r.cmd != CMD_UNUSED && !(r.cmd == CMD_FANOUT && r.slot >= FANOUT_DEPTH)) begin
      useful_sent++;
    end
  endtask

  task automatic try_lookup(key_t k);
    if (lookup_safe(k.top[31:24])) begin
      send_request(make_req(CMD_LOOKUP, SLOT_W'($urandom), k, $urandom));
    end
  endtask

  // Writes fresh sorted keys into the positions that a bucket owns. Keys often share
  // their upper fields so that comparisons have to reach the low word.
  task automatic fill_bucket(int unsigned b);
    logic [159:0] sorted [$];
    key_t         k;
    logic [23:0]  share_top;
    logic [63:0]  share_mid;
    int unsigned  base;
    share_top = 24'($urandom);
    share_mid = {$urandom, $urandom};
    base = bucket_base(b);
    repeat (bucket_size[b]) begin
      k = rand_key();
      k.top[31:24] = b[7:0];
      case ($urandom_range(2))
        0: ;
        1: k.top[23:0] = share_top;
        default: begin
          k.top[23:0] = share_top;
          k.mid = share_mid;
        end
      endcase
      sorted.push_back(k);
    end
    sorted.sort();
    foreach (sorted[i]) begin
      send_request(make_req(CMD_ENTRY, SLOT_W'(base + i), sorted[i], $urandom));
    end
  endtask

  function automatic key_t bucket_key(int unsigned b);
    key_t k;
    k = rand_key();
    k.top[31:24] = b[7:0];
    if (bucket_size[b] != 0 && $urandom_range(1)) begin
      k = stored_keys[bucket_base(b) + $urandom_range(bucket_size[b] - 1)];
    end
    return k;
  endfunction

  task automatic random_op();
    int unsigned  pick;
    int unsigned  b;
    int unsigned  bit_idx;
    logic [159:0] kv;
    logic [31:0]  disturbed;
    pick = $urandom_range(99);
    if (pick < 45) begin
      try_lookup(stored_keys[$urandom_range(index_total - 1)]);
    end else if (pick < 60) begin
      // Near misses: neighbours of a stored key, or one bit flipped.
      kv = stored_keys[$urandom_range(index_total - 1)];
      case ($urandom_range(2))
        0: kv = kv + 1'b1;
        1: kv = kv - 1'b1;
        default: begin
          bit_idx = $urandom_range(159);
          kv[bit_idx] = ~kv[bit_idx];
        end
      endcase
      try_lookup(kv);
    end else if (pick < 72) begin
      try_lookup(rand_key());
    end else if (pick < 80) begin
      b = $urandom_range(255);
      fill_bucket(b);
    end else if (pick < 86) begin
      // Disturb one fan-out word, which can leave a bucket empty, inverted or
      // saturated, probe around it, then restore the index.
      b = $urandom_range(255);
      disturbed = $urandom_range(1) ? $urandom_range(index_total)
                                    : $urandom_range(32'hFFFF_FFFF, MAX_ENTRIES + 1);
      send_request(make_req(CMD_FANOUT, SLOT_W'(b), rand_key(), disturbed));
      try_lookup(bucket_key(b));
      if (b < 255) try_lookup(bucket_key(b + 1));
      send_request(make_req(CMD_FANOUT, SLOT_W'(b), rand_key(), index_fanout[b]));
    end else if (pick < 91) begin
      send_request(make_req(CMD_FANOUT, SLOT_W'($urandom_range(4095, FANOUT_DEPTH)),
                            rand_key(), $urandom));
    end else if (pick < 95) begin
      send_request(make_req(CMD_UNUSED, SLOT_W'($urandom), rand_key(), $urandom));
    end else begin
      // Entries above the index lie in a bucket range only while a fan-out word is saturated.
      send_request(make_req(CMD_ENTRY, SLOT_W'($urandom_range(4095, index_total)),
                            rand_key(), $urandom));
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: found %0d position %0d offset %0h",
               found, position, entry_offset);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (found !== want.hit) begin
          $error("found: expected %0d, got %0d", want.hit, found);
          errors++;
        end
        if (position !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, position);
          errors++;
        end
        if (entry_offset !== want.ofs) begin
          $error("entry_offset: expected %0h, got %0h", want.ofs, entry_offset);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned big;
    int unsigned phase_end;
    useful_sent = 0;
    gap_pct = 34;
    // Bucket 0 holds positions 0 and 1, bucket 1 is empty, bucket 2 is inverted and
    // bucket 255 holds the top position through a saturated fan-out word.
    directed_rows = '{
      dir_row(CMD_FANOUT, 12'd0, '0, '0, '0, 32'd2, 1'b1, 1'b0, 12'd0, 32'd0),
      dir_row(CMD_FANOUT, 12'd1, '1, '1, '1, 32'd2, 1'b1, 1'b0, 12'd0, 32'd0),
      dir_row(CMD_FANOUT, 12'd2, '0, '0, '0, 32'd1, 1'b1, 1'b0, 12'd0, 32'd0),
      dir_row(CMD_FANOUT, 12'd254, '0, '0, '0, 32'd4095, 1'b1, 1'b0, 12'd0, 32'd0),
      dir_row(CMD_FANOUT, 12'd255, '0, '0, '0, 32'hFFFF_FFFF, 1'b1, 1'b0, 12'd0, 32'd0),
      dir_row(CMD_ENTRY, 12'd0, '0, '0, '0, 32'd0, 1'b1, 1'b0, 12'd0, 32'd0),
      dir_row(CMD_ENTRY, 12'd1, 32'h00FF_FFFF, '1, '1, 32'h1234_5678,
              1'b1, 1'b0, 12'd0, 32'd0),
      dir_row(CMD_ENTRY, 12'hFFF, '1, '1, '1, 32'hFFFF_FFFF, 1'b1, 1'b0, 12'd0, 32'd0),
      dir_row(CMD_FANOUT, 12'hFFF, '0, '0, '0, 32'd0, 1'b1, 1'b0, 12'd0, 32'd0),
      dir_row(CMD_FANOUT, 12'h100, '0, '0, '0, 32'd0, 1'b1, 1'b0, 12'd0, 32'd0),
      dir_row(CMD_UNUSED, 12'hFFF, '1, '1, '1, 32'hFFFF_FFFF, 1'b1, 1'b0, 12'd0, 32'd0),
      dir_row(CMD_LOOKUP, 12'hABC, '0, '0, '0, 32'hDEAD_BEEF, 1'b1, 1'b1, 12'd0, 32'd0),
      dir_row(CMD_LOOKUP, 12'h543, 32'h00FF_FFFF, '1, '1, 32'd0,
              1'b1, 1'b1, 12'd1, 32'h1234_5678),
      dir_row(CMD_LOOKUP, 12'hFFF, '0, '0, 64'd1, 32'hFFFF_FFFF,
              1'b0, 1'b0, 12'd0, 32'd0),
      dir_row(CMD_LOOKUP, 12'h000, 32'h0100_0000, '0, '0, 32'd0,
              1'b1, 1'b0, 12'd0, 32'd0),
      dir_row(CMD_LOOKUP, 12'h0F0, 32'h02AB_CDEF, '1, '0, 32'd5,
              1'b1, 1'b0, 12'd0, 32'd0),
      dir_row(CMD_LOOKUP, 12'h00F, '1, '1, '1, 32'd0, 1'b1, 1'b1, 12'hFFF, 32'hFFFF_FFFF),
      dir_row(CMD_LOOKUP, 12'h555, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE, 32'd9,
              1'b0, 1'b0, 12'd0, 32'd0),
      dir_row(CMD_LOOKUP, 12'hAAA, 32'h00FF_FFFF, '1, 64'hFFFF_FFFF_FFFF_FFFE, 32'd3,
              1'b0, 1'b0, 12'd0, 32'd0)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 34 : (phase == 1) ? 54 : 0;
      if (phase == 0) begin
        // Mostly tiny buckets with one deep bucket so that searches take many probes.
        big = $urandom_range(255);
        index_total = 0;
        for (int b = 0; b < FANOUT_DEPTH; b++) begin
          bucket_size[b] = (b == big) ? $urandom_range(160, 96) : $urandom_range(2);
          index_total += bucket_size[b];
          index_fanout[b] = index_total;
        end
        for (int b = 0; b < FANOUT_DEPTH; b++) fill_bucket(b);
        for (int b = 0; b < FANOUT_DEPTH; b++) begin
          send_request(make_req(CMD_FANOUT, SLOT_W'(b), rand_key(), index_fanout[b]));
        end
      end
      phase_end = useful_sent + PHASE_ITEMS;
      while (useful_sent < phase_end) random_op();
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
